FILE: src/lru_key_value_cache_core_assert.svh
// Assertion macros used by the cache back stage.
`ifndef LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define LKVC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define LKVC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/lkvc_pkg.sv
// Shared types and constants of the LRU key/value cache.
package lkvc_pkg;

    localparam int CAPACITY_DEFAULT    = 16;
    localparam int QUEUE_DEPTH_DEFAULT = 2;
    localparam int KEY_W               = 32;
    localparam int VAL_W               = 32;
    localparam int CAP_W               = 5;

    localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
    localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } t_op;

    typedef struct packed {
        t_op                     op;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] read_value;
        logic                    evicted;
        logic signed [KEY_W-1:0] evicted_key;
    } t_rsp;

endpackage

FILE: src/lkvc_if.sv
// Channel interfaces of the cache: request, response and configuration.
interface lkvc_req_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 kind;
    logic signed [lkvc_pkg::KEY_W-1:0]    key;
    logic signed [lkvc_pkg::VAL_W-1:0]    value;

    modport source (output valid, kind, key, value, input ready);
    modport sink   (input valid, kind, key, value, output ready);
endinterface

interface lkvc_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 hit;
    logic signed [lkvc_pkg::VAL_W-1:0]    read_value;
    logic                                 evicted;
    logic signed [lkvc_pkg::KEY_W-1:0]    evicted_key;

    modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
    modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

interface lkvc_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [lkvc_pkg::CAP_W-1:0]           capacity_in_use;

    modport source (output valid, capacity_in_use, input ready);
    modport sink   (input valid, capacity_in_use, output ready);
endinterface

FILE: src/lru_key_value_cache_core.sv
// Top level of the fully associative LRU key/value cache.
// Path: front register, queue, then the response register of the back stage.
// Throughput: one request per cycle while responses are taken, set by the
//   combinational key match and rank update of all CAPACITY back-stage entries.
// Reset (synchronous, active low): all entries invalid, ranks and fill count
//   zero, capacity setting 16, queue and response register empty.
module lru_key_value_cache_core #(
    parameter int CAPACITY    = lkvc_pkg::CAPACITY_DEFAULT,
    parameter int QUEUE_DEPTH = lkvc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lkvc_req_if.sink      i_req,
    lkvc_rsp_if.source    o_rsp,
    lkvc_cfg_if.sink      i_cfg
);

    // Front to queue: one decoded request per handshake.
    logic           w_push_valid;
    logic           w_push_ready;
    lkvc_pkg::t_req w_push_data;

    // Queue to back: the back stage pops only when its response register frees.
    logic           w_pop_valid;
    logic           w_pop_ready;
    lkvc_pkg::t_req w_pop_data;

    // Accept and decode; hold one request while the queue is full.
    lkvc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_data  (w_push_data)
    );

    // Decouple the two sides so each can stall on its own.
    lkvc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_data)
    );

    // Carry out gets and puts against the entry store; drive the response.
    lkvc_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_pop_data  (w_pop_data),
        .i_cfg       (i_cfg),
        .o_rsp       (o_rsp)
    );

endmodule

FILE: src/lkvc_front.sv
// Front stage: accept and decode a request, then push it to the queue.
module lkvc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    lkvc_req_if.sink          i_req,
    output logic              o_push_valid,
    input  logic              i_push_ready,
    output lkvc_pkg::t_req    o_push_data
);

    logic           r_valid;
    logic           n_valid;
    lkvc_pkg::t_req r_req;
    lkvc_pkg::t_req n_req;
    logic           w_take;

    assign i_req.ready  = !r_valid || i_push_ready;
    assign w_take       = i_req.valid && i_req.ready;
    assign o_push_valid = r_valid;
    assign o_push_data  = r_req;

    always_comb begin
        unique case (i_req.kind)
            lkvc_pkg::OP_PUT: n_req.op = lkvc_pkg::OP_PUT;
            default:          n_req.op = lkvc_pkg::OP_GET;
        endcase
        n_req.key   = i_req.key;
        n_req.value = i_req.value;
    end

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (i_push_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_req <= n_req;
        end
    end

endmodule

FILE: src/lkvc_queue.sv
// Short first-in first-out queue between the front and back stages.
module lkvc_queue #(
    parameter int DEPTH = lkvc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_valid,
    output logic              o_push_ready,
    input  lkvc_pkg::t_req    i_push_data,
    output logic              o_pop_valid,
    input  logic              i_pop_ready,
    output lkvc_pkg::t_req    o_pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    lkvc_pkg::t_req r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic [PW-1:0]  n_wr_ptr;
    logic [PW-1:0]  n_rd_ptr;
    logic [CW-1:0]  n_count;
    logic           w_push;
    logic           w_pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CW'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

FILE: src/lkvc_back.sv
// Back stage: entry store, key match, recency update and response register.
`include "lru_key_value_cache_core_assert.svh"

module lkvc_back #(
    parameter int CAPACITY = lkvc_pkg::CAPACITY_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_pop_valid,
    output logic              o_pop_ready,
    input  lkvc_pkg::t_req    i_pop_data,
    lkvc_cfg_if.sink          i_cfg,
    lkvc_rsp_if.source        o_rsp
);

    localparam int RW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int UW = $clog2(CAPACITY + 1);
    localparam int XW = (UW > lkvc_pkg::CAP_W) ? UW : lkvc_pkg::CAP_W;

    logic [CAPACITY-1:0]                   r_ent_valid;
    logic [CAPACITY-1:0]                   n_ent_valid;
    logic [lkvc_pkg::KEY_W-1:0]            r_key  [CAPACITY];
    logic [lkvc_pkg::VAL_W-1:0]            r_val  [CAPACITY];
    logic [RW-1:0]                         r_rank [CAPACITY];
    logic [RW-1:0]                         n_rank [CAPACITY];
    logic [UW-1:0]                         r_used;
    logic [UW-1:0]                         n_used;
    logic [lkvc_pkg::CAP_W-1:0]            r_cap;
    logic                                  r_out_valid;
    logic                                  n_out_valid;
    lkvc_pkg::t_rsp                        r_out;
    lkvc_pkg::t_rsp                        n_out;

    logic                                  w_slot_free;
    logic                                  w_fire;
    logic                                  w_is_put;
    logic                                  w_touch;
    logic                                  w_insert;
    logic                                  w_evict;
    logic                                  w_any_hit;
    logic                                  w_room;
    logic [CAPACITY-1:0]                   w_hit_vec;
    logic [CAPACITY-1:0]                   w_lru_vec;
    logic [CAPACITY-1:0]                   w_free_vec;
    logic [CAPACITY-1:0]                   w_tgt_vec;
    logic [lkvc_pkg::VAL_W-1:0]            w_hit_value;
    logic [lkvc_pkg::KEY_W-1:0]            w_lru_key;
    logic [RW-1:0]                         w_hit_rank;
    logic [RW-1:0]                         w_lru_rank;
    logic [RW-1:0]                         w_old_rank;
    logic [XW-1:0]                         w_cap_x;
    logic [XW-1:0]                         w_eff_cap;

    // Output register frees when empty or when its response is taken.
    assign w_slot_free = !r_out_valid || o_rsp.ready;
    assign o_pop_ready = w_slot_free;
    assign w_fire      = i_pop_valid && w_slot_free;
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.hit         = r_out.hit;
    assign o_rsp.read_value  = r_out.read_value;
    assign o_rsp.evicted     = r_out.evicted;
    assign o_rsp.evicted_key = r_out.evicted_key;

    // Clamp the capacity setting to 1..CAPACITY.
    always_comb begin
        w_cap_x = XW'(r_cap);
        if (w_cap_x == '0) begin
            w_eff_cap = XW'(1);
        end else if (w_cap_x > XW'(CAPACITY)) begin
            w_eff_cap = XW'(CAPACITY);
        end else begin
            w_eff_cap = w_cap_x;
        end
        w_room = (XW'(r_used) < w_eff_cap);
    end

    // Match, least-recent and first-free vectors over all entries.
    always_comb begin
        w_lru_rank  = RW'(r_used - UW'(1));
        w_hit_value = '0;
        w_lru_key   = '0;
        w_hit_rank  = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_hit_vec[i] = r_ent_valid[i] && (r_key[i] == i_pop_data.key);
            w_lru_vec[i] = r_ent_valid[i] && (r_rank[i] == w_lru_rank);
            w_hit_value  = w_hit_value | (w_hit_vec[i] ? r_val[i] : '0);
            w_hit_rank   = w_hit_rank  | (w_hit_vec[i] ? r_rank[i] : '0);
            w_lru_key    = w_lru_key   | (w_lru_vec[i] ? r_key[i] : '0);
        end
        w_any_hit  = |w_hit_vec;
        w_free_vec = ~r_ent_valid & (r_ent_valid + CAPACITY'(1));
    end

    // Decode the operation.
    always_comb begin
        unique case (i_pop_data.op)
            lkvc_pkg::OP_PUT: begin
                w_is_put = 1'b1;
                w_touch  = 1'b1;
            end
            default: begin
                w_is_put = 1'b0;
                w_touch  = w_any_hit;
            end
        endcase
        w_insert = w_is_put && !w_any_hit && w_room;
        w_evict  = w_is_put && !w_any_hit && !w_room;
        if (w_any_hit) begin
            w_tgt_vec  = w_hit_vec;
            w_old_rank = w_hit_rank;
        end else if (w_room) begin
            w_tgt_vec  = w_free_vec;
            w_old_rank = RW'(r_used);
        end else begin
            w_tgt_vec  = w_lru_vec;
            w_old_rank = w_lru_rank;
        end
    end

    // Next state of the entry flags, ranks and fill count.
    always_comb begin
        n_ent_valid = r_ent_valid;
        n_used      = r_used;
        for (int i = 0; i < CAPACITY; i++) begin
            n_rank[i] = r_rank[i];
        end
        if (w_fire && w_touch) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (w_tgt_vec[i]) begin
                    n_rank[i] = '0;
                end else if (r_ent_valid[i] && (r_rank[i] < w_old_rank)) begin
                    n_rank[i] = r_rank[i] + RW'(1);
                end
            end
        end
        if (w_fire && w_insert) begin
            n_ent_valid = r_ent_valid | w_tgt_vec;
            n_used      = r_used + UW'(1);
        end
    end

    // Build the response.
    always_comb begin
        n_out.hit         = w_any_hit;
        n_out.evicted     = w_evict;
        n_out.evicted_key = w_evict ? w_lru_key : '0;
        if (w_is_put) begin
            n_out.read_value = '0;
        end else if (w_any_hit) begin
            n_out.read_value = w_hit_value;
        end else begin
            n_out.read_value = lkvc_pkg::MISS_VALUE;
        end
        n_out_valid = r_out_valid;
        if (w_fire) begin
            n_out_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_valid <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
            r_cap       <= lkvc_pkg::CAP_RESET;
            for (int i = 0; i < CAPACITY; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_ent_valid <= n_ent_valid;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
            for (int i = 0; i < CAPACITY; i++) begin
                r_rank[i] <= n_rank[i];
            end
            if (i_cfg.valid && i_cfg.ready) begin
                r_cap <= i_cfg.capacity_in_use;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= n_out;
        end
        if (w_fire && w_is_put) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (w_tgt_vec[i]) begin
                    r_key[i] <= i_pop_data.key;
                    r_val[i] <= i_pop_data.value;
                end
            end
        end
    end

    `LKVC_ASSERT_IMPLIES(a_hit_onehot, i_clk, i_rst_n, i_pop_valid, $onehot0(w_hit_vec), "key matched more than one entry")
    `LKVC_ASSERT_IMPLIES(a_used_matches, i_clk, i_rst_n, 1'b1, $countones(r_ent_valid) == r_used, "fill count differs from valid entries")
    `LKVC_ASSERT_NEXT(a_evict_keeps_count, i_clk, i_rst_n, w_fire && w_evict, r_used == $past(r_used), "eviction changed fill count")
    `LKVC_ASSERT_NEXT(a_insert_claims, i_clk, i_rst_n, w_fire && w_insert, r_ent_valid != $past(r_ent_valid), "insert did not claim a free entry")

endmodule
